FILE: src/assert_macros.svh
// Assertion macros for the calibration RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AVTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("calibration assertion failed");

// Next-cycle implication, disabled during reset.
`define AVTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("calibration assertion failed");

`endif

FILE: src/avtc_pkg.sv
// Package for the supply and temperature calibration block.
// Holds constants, register indexes, microcode types and the microcode ROM.
`timescale 1ns / 1ps
`default_nettype none

package avtc_pkg;

    localparam int HREF_W        = 12;
    localparam int CAL_W         = 12;
    localparam int SUPPLY_W      = 16;
    localparam int OUT_W         = 16;
    localparam int PC_W          = 4;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    localparam int DEG_HIGH      = 110;
    localparam int DEG_LOW       = 30;
    localparam int OFFSET_HUND   = 3000;
    localparam int SCALE_HUNDRED = 100;
    localparam int SCALE_TEN     = 10;
    localparam int VDD_MAX       = 65535;
    localparam int TEMP_MAX      = 32767;
    localparam int TEMP_MIN      = -32768;

    // Divide by ten as a reciprocal multiply; the input is clamped first so that
    // the product stays exact and anything beyond the clamp still saturates.
    localparam int DIV10_IN_W    = 19;
    localparam int DIV10_P_W     = 38;
    localparam int DIV10_SHIFT   = 22;
    localparam int DIV10_MUL     = ((1 << DIV10_SHIFT) + SCALE_TEN - 1) / SCALE_TEN;
    localparam int DIV10_CLAMP   = (TEMP_MAX + 2) * SCALE_TEN;

    localparam logic [SUPPLY_W-1:0] RST_CAL_SUPPLY = 16'd3000;
    localparam logic [CAL_W-1:0]    RST_REF_CAL    = 12'd1670;
    localparam logic [CAL_W-1:0]    RST_TEMP_LOW   = 12'd670;
    localparam logic [CAL_W-1:0]    RST_TEMP_HIGH  = 12'd860;

    localparam logic [1:0] REG_CAL_SUPPLY = 2'd0;
    localparam logic [1:0] REG_REF_CAL    = 2'd1;
    localparam logic [1:0] REG_TEMP_LOW   = 2'd2;
    localparam logic [1:0] REG_TEMP_HIGH  = 2'd3;

    typedef enum logic [3:0] {
        OP_MUL_CR  = 4'd0,
        OP_DIV     = 4'd1,
        OP_SAT_V   = 4'd2,
        OP_MUL_SV  = 4'd3,
        OP_MUL_100 = 4'd4,
        OP_SUB_LOW = 4'd5,
        OP_MUL_DEG = 4'd6,
        OP_SIGN    = 4'd7,
        OP_OFFS    = 4'd8,
        OP_ABS10   = 4'd9,
        OP_FIN     = 4'd10,
        OP_ERR_V   = 4'd11,
        OP_ERR_T   = 4'd12,
        OP_DIV10   = 4'd13
    } t_op;

    typedef enum logic [1:0] {
        C_NONE     = 2'd0,
        C_REF_ZERO = 2'd1,
        C_TEMP_BAD = 2'd2
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ucw;

    localparam logic [PC_W-1:0] PC_ERR_V = 4'd14;
    localparam logic [PC_W-1:0] PC_ERR_T = 4'd15;

    function automatic t_ucw ucode(input logic [PC_W-1:0] pc);
        t_ucw w;
        w = '{op: OP_DIV, cond: C_NONE, target: '0};
        case (pc)
            4'd0:  w = '{op: OP_MUL_CR,  cond: C_REF_ZERO, target: PC_ERR_V};
            4'd1:  w = '{op: OP_DIV,     cond: C_NONE,     target: '0};
            4'd2:  w = '{op: OP_SAT_V,   cond: C_TEMP_BAD, target: PC_ERR_T};
            4'd3:  w = '{op: OP_MUL_SV,  cond: C_NONE,     target: '0};
            4'd4:  w = '{op: OP_MUL_100, cond: C_NONE,     target: '0};
            4'd5:  w = '{op: OP_DIV,     cond: C_NONE,     target: '0};
            4'd6:  w = '{op: OP_SUB_LOW, cond: C_NONE,     target: '0};
            4'd7:  w = '{op: OP_MUL_DEG, cond: C_NONE,     target: '0};
            4'd8:  w = '{op: OP_SIGN,    cond: C_NONE,     target: '0};
            4'd9:  w = '{op: OP_DIV,     cond: C_NONE,     target: '0};
            4'd10: w = '{op: OP_OFFS,    cond: C_NONE,     target: '0};
            4'd11: w = '{op: OP_ABS10,   cond: C_NONE,     target: '0};
            4'd12: w = '{op: OP_DIV10,   cond: C_NONE,     target: '0};
            4'd13: w = '{op: OP_FIN,     cond: C_NONE,     target: '0};
            4'd14: w = '{op: OP_ERR_V,   cond: C_NONE,     target: '0};
            4'd15: w = '{op: OP_ERR_T,   cond: C_NONE,     target: '0};
            default: w = '{op: OP_ERR_V, cond: C_NONE,     target: '0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: src/adc_vdd_temp_calibration.sv
// Top level of the ADC supply and temperature calibration block.
// Depends on avtc_pkg, avtc_divider and assert_macros.svh.
//
// Samples arrive in pairs: the reference-channel beat is registered and gives no
// result; the temperature-channel beat starts a microcoded program that computes
// supply voltage in mV and temperature in tenths of a degree and then delivers
// one result beat. The bit-serial divider serves the three divisions by a
// register value at one quotient bit per cycle; the final divide by ten is a
// reciprocal multiply. Input is stalled while the program runs.
// A finished result waits in the output register while the next reference beat
// is taken. Calibration registers sit on an APB port at byte addresses 0, 4, 8, 12.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module adc_vdd_temp_calibration
    import avtc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [OUT_W-1:0]            o_vdd_mv,
    output logic signed [OUT_W-1:0]     o_temp_tenths,
    output logic                        o_div_error,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready
);

    localparam int SV_W   = SAMPLE_BITS + SUPPLY_W;
    localparam int PROD_W = SV_W + 7;
    localparam int ACC_W  = PROD_W + 8;

    localparam logic signed [ACC_W-1:0] K_TMAX  = ACC_W'(TEMP_MAX);
    localparam logic signed [ACC_W-1:0] K_TMIN  = ACC_W'(TEMP_MIN);
    localparam logic signed [ACC_W-1:0] K_OFFS  = ACC_W'(OFFSET_HUND);
    localparam logic signed [ACC_W-1:0] K_CLAMP = ACC_W'(DIV10_CLAMP);
    localparam logic [DIV10_P_W-1:0]    K_RECIP = DIV10_P_W'(DIV10_MUL);
    localparam logic signed [7:0]       K_DEG   = 8'(DEG_HIGH - DEG_LOW);

    // Configuration registers
    logic [SUPPLY_W-1:0] r_cal_supply;
    logic [CAL_W-1:0]    r_ref_cal;
    logic [CAL_W-1:0]    r_temp_low;
    logic [CAL_W-1:0]    r_temp_high;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_supply <= RST_CAL_SUPPLY;
            r_ref_cal    <= RST_REF_CAL;
            r_temp_low   <= RST_TEMP_LOW;
            r_temp_high  <= RST_TEMP_HIGH;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_CAL_SUPPLY: r_cal_supply <= pwdata[SUPPLY_W-1:0];
                REG_REF_CAL:    r_ref_cal    <= pwdata[CAL_W-1:0];
                REG_TEMP_LOW:   r_temp_low   <= pwdata[CAL_W-1:0];
                REG_TEMP_HIGH:  r_temp_high  <= pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CAL_SUPPLY: prdata = DATA_W'(r_cal_supply);
            REG_REF_CAL:    prdata = DATA_W'(r_ref_cal);
            REG_TEMP_LOW:   prdata = DATA_W'(r_temp_low);
            REG_TEMP_HIGH:  prdata = DATA_W'(r_temp_high);
            default:        prdata = '0;
        endcase
    end

    // Sequencer control
    logic            r_run;
    logic            r_phase;
    logic            r_div_act;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            n_run;
    logic            r_out_valid;

    // Datapath
    logic [HREF_W-1:0]      r_href;
    logic [SAMPLE_BITS-1:0] r_s;
    logic signed [ACC_W-1:0] r_acc;
    logic [SUPPLY_W-1:0]    r_den;
    logic                   r_neg;
    logic [OUT_W-1:0]       r_vdd;
    logic [OUT_W-1:0]       r_out_vdd;
    logic [OUT_W-1:0]       r_out_temp;
    logic                   r_out_err;

    t_ucw ucw;
    logic in_acc;
    logic is_final;
    logic out_free;
    logic emit;
    logic jump;
    logic div_start;
    logic div_done;
    logic div_fin;
    logic [ACC_W-1:0] div_quo;

    logic [27:0]               mul_cr;
    logic [SV_W-1:0]           mul_sv;
    logic [ACC_W-1:0]          mul_100;
    logic [18:0]               low_100;
    logic signed [ACC_W-1:0]   mul_deg;
    logic signed [CAL_W:0]     span;
    logic [CAL_W:0]            span_abs;
    logic signed [ACC_W-1:0]   acc_abs;
    logic [ACC_W-1:0]          acc_clip;
    logic [DIV10_P_W-1:0]      div10_prod;
    logic signed [ACC_W-1:0]   acc_sgn;
    logic signed [ACC_W-1:0]   acc_offs;
    logic [OUT_W-1:0]          temp_sat;
    logic                      ref_zero;
    logic                      temp_bad;

    assign ucw      = ucode(r_pc);
    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = r_run;
    assign is_final = (ucw.op == OP_FIN) || (ucw.op == OP_ERR_V) || (ucw.op == OP_ERR_T);
    assign out_free = !r_out_valid || !i_stall;
    assign emit     = r_run && is_final && out_free;

    assign ref_zero = (r_href == '0);
    assign temp_bad = (span == '0) || (r_cal_supply == '0);

    always_comb begin
        case (ucw.cond)
            C_REF_ZERO: jump = ref_zero;
            C_TEMP_BAD: jump = temp_bad;
            default:    jump = 1'b0;
        endcase
    end

    assign div_start = r_run && (ucw.op == OP_DIV) && !r_div_act;
    assign div_fin   = r_run && (ucw.op == OP_DIV) && r_div_act && div_done;

    always_comb begin
        n_pc  = r_pc;
        n_run = r_run;
        if (in_acc && r_phase) begin
            n_pc  = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            if (ucw.op == OP_DIV) begin
                if (r_div_act && div_done) begin
                    n_pc = r_pc + PC_W'(1);
                end
            end else if (is_final) begin
                if (out_free) begin
                    n_run = 1'b0;
                end
            end else if (jump) begin
                n_pc = ucw.target;
            end else begin
                n_pc = r_pc + PC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_pc        <= '0;
            r_phase     <= 1'b0;
            r_div_act   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_run <= n_run;
            r_pc  <= n_pc;
            if (in_acc) begin
                r_phase <= !r_phase;
            end
            if (div_start) begin
                r_div_act <= 1'b1;
            end else if (div_done) begin
                r_div_act <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic
    assign mul_cr     = {12'd0, r_cal_supply} * {16'd0, r_ref_cal};
    assign mul_sv     = SV_W'(r_s) * SV_W'(r_vdd);
    assign mul_100    = ACC_W'(r_acc[SV_W-1:0]) * ACC_W'(SCALE_HUNDRED);
    assign low_100    = {7'd0, r_temp_low} * 19'(SCALE_HUNDRED);
    assign mul_deg    = r_acc * K_DEG;
    assign span       = $signed({1'b0, r_temp_high}) - $signed({1'b0, r_temp_low});
    assign span_abs   = span[CAL_W] ? -span : span;
    assign acc_abs    = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign acc_clip   = (acc_abs > K_CLAMP) ? K_CLAMP : acc_abs;
    assign div10_prod = DIV10_P_W'(r_acc[DIV10_IN_W-1:0]) * K_RECIP;
    assign acc_sgn    = r_neg ? -r_acc : r_acc;
    assign acc_offs   = acc_sgn + K_OFFS;

    always_comb begin
        if (acc_sgn > K_TMAX) begin
            temp_sat = OUT_W'(TEMP_MAX);
        end else if (acc_sgn < K_TMIN) begin
            temp_sat = OUT_W'(TEMP_MIN);
        end else begin
            temp_sat = acc_sgn[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (!r_phase) begin
                r_href <= HREF_W'(i_sample);
            end else begin
                r_s <= i_sample;
            end
        end
        if (r_run) begin
            case (ucw.op)
                OP_MUL_CR: begin
                    r_acc <= ACC_W'(mul_cr);
                    r_den <= SUPPLY_W'(r_href);
                end
                OP_DIV: begin
                    if (r_div_act && div_done) begin
                        r_acc <= div_quo;
                    end
                end
                OP_SAT_V: begin
                    if (r_acc > ACC_W'(VDD_MAX)) begin
                        r_vdd <= OUT_W'(VDD_MAX);
                    end else begin
                        r_vdd <= r_acc[OUT_W-1:0];
                    end
                end
                OP_MUL_SV: r_acc <= ACC_W'(mul_sv);
                OP_MUL_100: begin
                    r_acc <= mul_100;
                    r_den <= r_cal_supply;
                end
                OP_SUB_LOW: r_acc <= r_acc - $signed(ACC_W'(low_100));
                OP_MUL_DEG: r_acc <= mul_deg;
                OP_SIGN: begin
                    r_neg <= r_acc[ACC_W-1] ^ span[CAL_W];
                    r_acc <= acc_abs;
                    r_den <= SUPPLY_W'(span_abs);
                end
                OP_OFFS: r_acc <= acc_offs;
                OP_ABS10: begin
                    r_neg <= r_acc[ACC_W-1];
                    r_acc <= acc_clip;
                end
                OP_DIV10: r_acc <= ACC_W'(div10_prod[DIV10_P_W-1:DIV10_SHIFT]);
                default: ;
            endcase
        end
        if (emit) begin
            case (ucw.op)
                OP_FIN: begin
                    r_out_vdd  <= r_vdd;
                    r_out_temp <= temp_sat;
                    r_out_err  <= 1'b0;
                end
                OP_ERR_T: begin
                    r_out_vdd  <= r_vdd;
                    r_out_temp <= '0;
                    r_out_err  <= 1'b1;
                end
                default: begin
                    r_out_vdd  <= '0;
                    r_out_temp <= '0;
                    r_out_err  <= 1'b1;
                end
            endcase
        end
    end

    avtc_divider #(
        .DIVIDEND_W (ACC_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_valid       = r_out_valid;
    assign o_vdd_mv      = r_out_vdd;
    assign o_temp_tenths = r_out_temp;
    assign o_div_error   = r_out_err;

    `AVTC_ASSERT_NOW(a_div_start_op, div_start, r_run && ucw.op == OP_DIV)
    `AVTC_ASSERT_NOW(a_div_done_owned, div_done, r_div_act)
    `AVTC_ASSERT_NEXT(a_temp_starts, in_acc && r_phase, r_run && r_pc == PC_W'(0))
    `AVTC_ASSERT_NEXT(a_div_advance, div_fin, r_pc == $past(r_pc) + PC_W'(1))

endmodule

`default_nettype wire

FILE: src/avtc_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle, 16-bit divisor.
// Uses avtc_pkg for the divisor width; zero divisors are screened early in a run.
`timescale 1ns / 1ps
`default_nettype none

module avtc_divider
    import avtc_pkg::*;
#(
    parameter int DIVIDEND_W = 43
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [SUPPLY_W-1:0]   i_divisor,
    output logic                       o_done,
    output logic [DIVIDEND_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [SUPPLY_W:0]     r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [SUPPLY_W-1:0]   r_den;

    logic [SUPPLY_W:0]     shifted;
    logic [SUPPLY_W+1:0]   diff;

    assign shifted = {r_rem[SUPPLY_W-1:0], r_quo[DIVIDEND_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (!diff[SUPPLY_W+1]) begin
                r_rem <= diff[SUPPLY_W:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire
